/* rtl/core/miller_rabin_prime_test_defines.svh */
// Assertion macros shared by the Miller-Rabin test block.
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MRPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MRPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mrpt_pkg.sv */
// Types, widths and codes shared by the Miller-Rabin test block.
package mrpt_pkg;

	localparam int NUM_W    = 63;
	localparam int CNT_W    = $clog2(NUM_W);
	localparam int S_DATA_W = ((2 * NUM_W + 7) / 8) * 8;
	localparam int M_DATA_W = 8;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_RED_STEP,
		CMD_TZ_INIT,
		CMD_TZ_STEP,
		CMD_POW_INIT,
		CMD_SQ_START,
		CMD_MULA_START,
		CMD_MUL_STEP,
		CMD_WB,
		CMD_SQL_WB,
		CMD_BIT_NEXT
	} dp_cmd_t;

	typedef struct packed {
		logic n_two;
		logic n_bad;
		logic rem_zero;
		logic u_odd;
		logic mcnt_zero;
		logic bcnt_zero;
		logic e_top;
		logic x_one;
		logic x_nm1;
		logic acc_one;
		logic twos_zero;
		logic last;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RED,
		S_CHKA,
		S_TZ,
		S_POW,
		S_MUL,
		S_WB,
		S_POWM,
		S_POWNX,
		S_SQL,
		S_END
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_POWSQ,
		PH_POWMUL,
		PH_SQL
	} mul_phase_t;

endpackage

/* rtl/core/mrpt_dp.sv */
// Datapath: operand registers, bit-serial modular reduction and multiply.
`include "miller_rabin_prime_test_defines.svh"

module mrpt_dp
	import mrpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  num_t       candidate,
	input  num_t       witness,
	input  logic       last_witness,
	output dp_status_t st
);

	num_t n_q;
	num_t w_q;
	num_t rem_q;
	num_t u_q;
	num_t x_q;
	num_t ma_q;
	num_t mb_q;
	num_t acc_q;
	cnt_t mcnt_q;
	cnt_t bcnt_q;
	cnt_t twos_q;
	logic last_q;

	logic [NUM_W:0] red_sh;
	logic [NUM_W:0] acc_sum;
	logic [NUM_W:0] ma_dbl;
	num_t           red_nx;
	num_t           acc_nx;
	num_t           ma_nx;

	// v < 2m: one conditional subtract brings it below m
	function automatic num_t mod_fold(logic [NUM_W:0] v, num_t m);
		logic [NUM_W:0] diff;
		diff = v - {1'b0, m};
		return diff[NUM_W] ? v[NUM_W-1:0] : diff[NUM_W-1:0];
	endfunction

	assign red_sh  = {rem_q, w_q[NUM_W-1]};
	assign acc_sum = {1'b0, acc_q} + {1'b0, (mb_q[0] ? ma_q : '0)};
	assign ma_dbl  = {ma_q, 1'b0};
	assign red_nx  = mod_fold(red_sh, n_q);
	assign acc_nx  = mod_fold(acc_sum, n_q);
	assign ma_nx   = mod_fold(ma_dbl, n_q);

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				n_q    <= candidate;
				w_q    <= witness;
				rem_q  <= '0;
				last_q <= last_witness;
				mcnt_q <= cnt_t'(NUM_W - 1);
			end
			CMD_RED_STEP: begin
				rem_q  <= red_nx;
				w_q    <= {w_q[NUM_W-2:0], 1'b0};
				mcnt_q <= mcnt_q - 1'b1;
			end
			CMD_TZ_INIT: begin
				u_q    <= {n_q[NUM_W-1:1], 1'b0};
				twos_q <= '0;
			end
			CMD_TZ_STEP: begin
				u_q    <= {1'b0, u_q[NUM_W-1:1]};
				twos_q <= twos_q + 1'b1;
			end
			CMD_POW_INIT: begin
				x_q    <= num_t'(1);
				bcnt_q <= cnt_t'(NUM_W - 1);
			end
			CMD_SQ_START: begin
				ma_q   <= x_q;
				mb_q   <= x_q;
				acc_q  <= '0;
				mcnt_q <= cnt_t'(NUM_W - 1);
			end
			CMD_MULA_START: begin
				ma_q   <= rem_q;
				mb_q   <= x_q;
				acc_q  <= '0;
				mcnt_q <= cnt_t'(NUM_W - 1);
			end
			CMD_MUL_STEP: begin
				acc_q  <= acc_nx;
				ma_q   <= ma_nx;
				mb_q   <= {1'b0, mb_q[NUM_W-1:1]};
				mcnt_q <= mcnt_q - 1'b1;
			end
			CMD_WB: begin
				x_q <= acc_q;
			end
			CMD_SQL_WB: begin
				x_q    <= acc_q;
				twos_q <= twos_q - 1'b1;
			end
			CMD_BIT_NEXT: begin
				u_q    <= {u_q[NUM_W-2:0], 1'b0};
				bcnt_q <= bcnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.n_two     = (n_q == num_t'(2));
		st.n_bad     = (n_q < num_t'(2)) || !n_q[0];
		st.rem_zero  = (rem_q == '0);
		st.u_odd     = u_q[0];
		st.mcnt_zero = (mcnt_q == '0);
		st.bcnt_zero = (bcnt_q == '0);
		st.e_top     = u_q[NUM_W-1];
		st.x_one     = (x_q == num_t'(1));
		st.x_nm1     = (x_q == {n_q[NUM_W-1:1], 1'b0});
		st.acc_one   = (acc_q == num_t'(1));
		st.twos_zero = (twos_q == '0);
		st.last      = last_q;
	end

	`MRPT_ASSERT_NOW(a_mul_reduced, (cmd == CMD_MUL_STEP), (acc_q < n_q) && (ma_q < n_q), "multiply operands not reduced")
	`MRPT_ASSERT_NEXT(a_red_reduced, (cmd == CMD_RED_STEP), (rem_q < n_q), "witness remainder not reduced")

endmodule

/* rtl/core/mrpt_ctrl.sv */
// Controller: round sequencing, sticky composite flag and verdict register.
`include "miller_rabin_prime_test_defines.svh"

module mrpt_ctrl
	import mrpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic       verdict,
	output dp_cmd_t    cmd,
	input  dp_status_t st
);

	ctrl_state_t state_q, state_d;
	mul_phase_t  phase_q, phase_d;
	logic        composite_q;
	logic        m_tvalid_q;
	logic        verdict_q;
	logic        round_fail;
	logic        out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_POWSQ;
			composite_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (out_load) begin
				composite_q <= 1'b0;
			end else if (round_fail) begin
				composite_q <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			verdict_q <= !composite_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		cmd        = CMD_NOP;
		round_fail = 1'b0;
		out_load   = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd     = CMD_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (st.n_two) begin
					state_d = S_END;
				end else if (st.n_bad) begin
					round_fail = 1'b1;
					state_d    = S_END;
				end else begin
					state_d = S_RED;
				end
			end
			S_RED: begin
				cmd = CMD_RED_STEP;
				if (st.mcnt_zero) begin
					state_d = S_CHKA;
				end
			end
			S_CHKA: begin
				if (st.rem_zero) begin
					state_d = S_END;
				end else begin
					cmd     = CMD_TZ_INIT;
					state_d = S_TZ;
				end
			end
			S_TZ: begin
				if (st.u_odd) begin
					cmd     = CMD_POW_INIT;
					state_d = S_POW;
				end else begin
					cmd = CMD_TZ_STEP;
				end
			end
			S_POW: begin
				cmd     = CMD_SQ_START;
				phase_d = PH_POWSQ;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd = CMD_MUL_STEP;
				if (st.mcnt_zero) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				unique case (phase_q)
					PH_POWSQ: begin
						cmd     = CMD_WB;
						state_d = S_POWM;
					end
					PH_POWMUL: begin
						cmd     = CMD_WB;
						state_d = S_POWNX;
					end
					PH_SQL: begin
						// nontrivial square root of one
						if (st.acc_one && !st.x_one && !st.x_nm1) begin
							round_fail = 1'b1;
							state_d    = S_END;
						end else begin
							cmd     = CMD_SQL_WB;
							state_d = S_SQL;
						end
					end
					default: begin
						state_d = S_END;
					end
				endcase
			end
			S_POWM: begin
				if (st.e_top) begin
					cmd     = CMD_MULA_START;
					phase_d = PH_POWMUL;
					state_d = S_MUL;
				end else begin
					state_d = S_POWNX;
				end
			end
			S_POWNX: begin
				cmd     = CMD_BIT_NEXT;
				state_d = st.bcnt_zero ? S_SQL : S_POW;
			end
			S_SQL: begin
				if (st.twos_zero) begin
					round_fail = !st.x_one;
					state_d    = S_END;
				end else begin
					cmd     = CMD_SQ_START;
					phase_d = PH_SQL;
					state_d = S_MUL;
				end
			end
			S_END: begin
				if (!st.last) begin
					state_d = S_IDLE;
				end else if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign verdict  = verdict_q;

	`MRPT_ASSERT_NEXT(a_verdict_clears, out_load, m_tvalid_q && !composite_q, "verdict beat not raised or flag not cleared")
	`MRPT_ASSERT_NEXT(a_beat_drains, (m_tvalid_q && m_tready && !out_load), !m_tvalid_q, "taken verdict beat still shown")

endmodule

/* rtl/core/miller_rabin_prime_test.sv */
// Miller-Rabin primality test, one witness per input beat, one verdict per candidate.
// Each input beat carries a candidate n, a witness and a last flag; the verdict beat
// appears only after the beat marked last. A beat ends early when n is 2, below 2 or
// even; otherwise the witness is first reduced modulo n, one step is taken per trailing
// zero of n-1, and then the modular products follow: 63 squarings, one multiply per set
// bit of u, and up to t further squarings. The shift-add modular multiplier takes one
// multiplier bit per cycle. A new beat is taken once the previous round is finished,
// even while the verdict still waits on the output.
module miller_rabin_prime_test
	import mrpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // candidate[62:0], witness[125:63], zero pad
	input  logic                s_tlast,  // last_witness
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // probably_prime[0], zero pad
);

	dp_cmd_t    cmd;
	dp_status_t st;
	logic       verdict;

	mrpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.verdict  (verdict),
		.cmd      (cmd),
		.st       (st)
	);

	mrpt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.candidate    (s_tdata[NUM_W-1:0]),
		.witness      (s_tdata[2*NUM_W-1:NUM_W]),
		.last_witness (s_tlast),
		.st           (st)
	);

	assign m_tdata = {{(M_DATA_W-1){1'b0}}, verdict};

endmodule
